>>> hdl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants for the LSB-first bit packer
// Fixed field widths of the item and result channels, and the queue status
// group passed between the queue and its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

    localparam int BYTE_W   = 8;   // stream byte
    localparam int PART_W   = 7;   // bits held in the incomplete byte
    localparam int PCNT_W   = 3;   // count of bits in the incomplete byte
    localparam int IN_CNT_W = 6;   // bit_count field
    localparam int VALUE_W  = 32;  // field_value field
    localparam int TOTAL_W  = 32;  // running bit total

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

>>> hdl/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front: field append and byte classification
// Merges the saturated, masked field into the partial byte, works out how
// many result bytes the item yields and updates the carried state.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_front
    import lbp_pkg::*;
#(
    parameter int LIMIT  = 32,
    parameter int BUF_W  = 40,
    parameter int CNT_W  = 3,
    parameter int HAVE_W = 6
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [IN_CNT_W-1:0] bit_count,
    input  wire logic [VALUE_W-1:0]  field_value,
    input  wire logic                flush,
    output logic      [BUF_W-1:0]    acc_bits,
    output logic      [CNT_W-1:0]    nbytes,
    output logic      [TOTAL_W-1:0]  total
);

    logic [PART_W-1:0]   partial_reg, partial_next;
    logic [PCNT_W-1:0]   pcount_reg, pcount_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    logic [IN_CNT_W-1:0] n_sat;
    logic [LIMIT-1:0]    value_m;
    logic [HAVE_W-1:0]   have;
    logic [CNT_W-1:0]    nfull;
    logic [2:0]          rem;
    logic [BUF_W-1:0]    shifted;

    always_comb
    begin
        if (bit_count > IN_CNT_W'(LIMIT))
        begin
            n_sat = IN_CNT_W'(LIMIT);
        end
        else
        begin
            n_sat = bit_count;
        end

        for (int i = 0; i < LIMIT; i++)
        begin
            value_m[i] = field_value[i] & (IN_CNT_W'(i) < n_sat);
        end

        acc_bits = BUF_W'(partial_reg) | (BUF_W'(value_m) << pcount_reg);
        have     = HAVE_W'(pcount_reg) + HAVE_W'(n_sat);
        nfull    = CNT_W'(have >> 3);
        rem      = have[2:0];
        nbytes   = nfull + CNT_W'(flush && (rem != 3'd0));

        // leftover bits after the full bytes leave
        shifted  = acc_bits >> {nfull, 3'b000};

        if (flush)
        begin
            partial_next = '0;
            pcount_next  = '0;
        end
        else
        begin
            partial_next = shifted[PART_W-1:0];
            pcount_next  = rem;
        end

        total_next = total_reg + TOTAL_W'(n_sat);
        total      = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pcount_reg  <= '0;
            total_reg   <= '0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            pcount_reg  <= pcount_next;
            total_reg   <= total_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lbp_queue.sv
// ----------------------------------------------------------------------------
// lbp_queue: small queue between front and back
// Register-based FIFO holding classified items; combinational head read.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_queue
    import lbp_pkg::*;
#(
    parameter int W     = 75,
    parameter int DEPTH = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    input  wire logic         rd_en,
    output logic      [W-1:0] rd_data,
    output fifo_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

>>> hdl/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back: result drain
// Walks the bytes of the head entry, one result per transfer, and retires
// the entry on its last result. An entry with no bytes gives one empty result.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_back
    import lbp_pkg::*;
#(
    parameter int BUF_W = 40,
    parameter int CNT_W = 3
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fifo_status_t       status,
    input  wire logic [BUF_W-1:0]   acc_bits,
    input  wire logic [CNT_W-1:0]   nbytes,
    input  wire logic               pop,
    output logic                    retire,
    output logic                    byte_valid,
    output logic      [BYTE_W-1:0]  byte_out,
    output logic                    last
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             take;

    always_comb
    begin
        byte_valid = (nbytes != '0);
        byte_out   = byte_valid ? acc_bits[{idx_reg, 3'b000} +: BYTE_W] : '0;
        last       = !byte_valid || (idx_reg == CNT_W'(nbytes - 1'b1));
        take       = pop && !status.empty;
        retire     = take && last;

        idx_next = idx_reg;
        if (retire)
        begin
            idx_next = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!status.empty && byte_valid) |-> (idx_reg < nbytes))
        else $error("byte index past end of entry");

    a_empty_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!status.empty && !byte_valid) |-> (last && idx_reg == '0))
        else $error("empty result not final");

endmodule

`default_nettype wire

>>> hdl/lsb_first_bit_packer_core.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core: LSB-first bit stream packer
// Appends 0..32-bit fields to a bit stream, emits every completed byte and,
// on flush, the zero-padded tail byte, each with the running bit total.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  ---------------------------------------------
//  item in   push / full        bit_count, field_value, flush
//  result    empty / pop        byte_valid, byte_out, last, total_bits
//
//  Cycles: the front takes one item per clock unless full; the back delivers
//  one result per pop, so an item costs max(1, bytes) result transfers (at most five).
//  The queue between them is FIFO_DEPTH entries; full rises only when it fills.
//  Reset clears the partial byte, bit total, queue pointers and byte index.
//  An accepted item is registered in the queue and is then visible on the result side.
//
`default_nettype none

module lsb_first_bit_packer_core
    import lbp_pkg::*;
#(
    parameter int MAX_FIELD_BITS = 32,
    parameter int FIFO_DEPTH     = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // item side
    input  wire logic                push,
    output logic                     full,
    input  wire logic [IN_CNT_W-1:0] bit_count,
    input  wire logic [VALUE_W-1:0]  field_value,
    input  wire logic                flush,
    // result side
    output logic                     empty,
    input  wire logic                pop,
    output logic                     byte_valid,
    output logic      [BYTE_W-1:0]   byte_out,
    output logic                     last,
    output logic      [TOTAL_W-1:0]  total_bits
);

    // Field counts saturate at the smaller of the parameter and the field width.
    localparam int LIMIT   = (MAX_FIELD_BITS < VALUE_W) ? MAX_FIELD_BITS : VALUE_W;
    // Partial byte plus one field.
    localparam int ACC_W   = LIMIT + PART_W;
    // Full bytes from the accumulator plus a possible flush byte.
    localparam int MAXB    = ACC_W / BYTE_W + 1;
    localparam int BUF_W   = MAXB * BYTE_W;
    localparam int CNT_W   = $clog2(MAXB + 1);
    localparam int HAVE_W  = $clog2(ACC_W + 1);
    localparam int ENTRY_W = BUF_W + CNT_W + TOTAL_W;

    fifo_status_t       q_status;
    logic               accept;
    logic               retire;

    logic [BUF_W-1:0]   f_acc;
    logic [CNT_W-1:0]   f_nbytes;
    logic [TOTAL_W-1:0] f_total;

    logic [ENTRY_W-1:0] q_wr_data;
    logic [ENTRY_W-1:0] q_rd_data;

    logic [BUF_W-1:0]   h_acc;
    logic [CNT_W-1:0]   h_nbytes;

    // Item transfer: the front state advances only when the queue takes it.
    assign full   = q_status.full;
    assign empty  = q_status.empty;
    assign accept = push && !q_status.full;

    lbp_front #(
        .LIMIT  (LIMIT),
        .BUF_W  (BUF_W),
        .CNT_W  (CNT_W),
        .HAVE_W (HAVE_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .bit_count   (bit_count),
        .field_value (field_value),
        .flush       (flush),
        .acc_bits    (f_acc),
        .nbytes      (f_nbytes),
        .total       (f_total)
    );

    // Queue entry: accumulator bytes, byte count, running total.
    assign q_wr_data = {f_acc, f_nbytes, f_total};

    lbp_queue #(
        .W     (ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (q_wr_data),
        .rd_en   (retire),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    assign h_acc      = q_rd_data[ENTRY_W-1 -: BUF_W];
    assign h_nbytes   = q_rd_data[TOTAL_W +: CNT_W];
    // Every result of an item carries the same total.
    assign total_bits = q_rd_data[TOTAL_W-1:0];

    lbp_back #(
        .BUF_W (BUF_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (q_status),
        .acc_bits   (h_acc),
        .nbytes     (h_nbytes),
        .pop        (pop),
        .retire     (retire),
        .byte_valid (byte_valid),
        .byte_out   (byte_out),
        .last       (last)
    );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for lsb_first_bit_packer_core
// Feeds fields through the push/full side and drains bytes through the
// empty/pop side. A directed table comes first, then random fields under
// several idle/stall patterns. Every popped result is compared with a local
// model or typed-in result: byte stream, flush padding and running bit total.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import lbp_pkg::*;

    localparam int FIELD_BITS_MAX = 32;   // DUT default MAX_FIELD_BITS
    localparam int MAX_RESULTS    = 5;    // 7 held bits + 32 new -> 4 bytes + tail
    localparam int QUIET_LIMIT    = 4000; // cycles with no transfer on either side
    localparam int DRAIN_CYCLES   = 16;
    localparam int RAND_PER_PHASE = 102;
    localparam int N_DIR          = 21;

    typedef struct packed {
        logic               valid;
        logic [BYTE_W-1:0]  value;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } packed_byte_t;

    typedef struct packed {
        logic [IN_CNT_W-1:0] cnt;
        logic [VALUE_W-1:0]  val;
        logic                fl;
        logic                typed;    // 1: use the typed-in result below
        logic                t_valid;
        logic [BYTE_W-1:0]   t_byte;
        logic [TOTAL_W-1:0]  t_total;
    } field_row_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [IN_CNT_W-1:0] bit_count = '0;
    logic [VALUE_W-1:0]  field_value = '0;
    logic                flush = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic                byte_valid;
    logic [BYTE_W-1:0]   byte_out;
    logic                last;
    logic [TOTAL_W-1:0]  total_bits;

    // model state
    logic [PART_W-1:0]   tail_bits = '0;
    logic [PCNT_W-1:0]   tail_len = '0;
    logic [TOTAL_W-1:0]  stream_bits = '0;

    packed_byte_t        pending_bytes[$];
    int                  error_count = 0;
    int                  send_idle_pct = 0;
    int                  pop_stall_pct = 0;
    logic                stream_done = 1'b0;

    // Directed fields. Typed rows each give a single result that is obvious
    // from the rules; the others go through the model.
    field_row_t dir_rows [0:N_DIR-1] = '{
        // zero count right after reset: nothing appended
        '{6'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 8'h00, 32'd0},
        // one whole byte
        '{6'd8,  32'h0000_00A5, 1'b0, 1'b1, 1'b1, 8'hA5, 32'd8},
        // flush with nothing held emits nothing extra
        '{6'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b0, 8'h00, 32'd8},
        // bits above the count are dropped, no byte completes
        '{6'd3,  32'hFFFF_FFFD, 1'b0, 1'b1, 1'b0, 8'h00, 32'd11},
        // flush pads the tail with zeros, padding not counted
        '{6'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b1, 8'h05, 32'd11},
        '{6'd32, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        // oversized counts saturate to 32
        '{6'd63, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd33, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd1,  32'h0000_0001, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd7,  32'h0000_007F, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        // seven held bits plus 32 with flush: five results
        '{6'd32, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd7,  32'h0000_0080, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd1,  32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd16, 32'hAAAA_5555, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd5,  32'h0000_001F, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd40, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd31, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd6,  32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd2,  32'h0000_0003, 1'b0, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd32, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0},
        '{6'd48, 32'hC3C3_C3C3, 1'b1, 1'b0, 1'b0, 8'h00, 32'd0}
    };

    lsb_first_bit_packer_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .bit_count   (bit_count),
        .field_value (field_value),
        .flush       (flush),
        .empty       (empty),
        .pop         (pop),
        .byte_valid  (byte_valid),
        .byte_out    (byte_out),
        .last        (last),
        .total_bits  (total_bits)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Append one field to the model stream and return the results it causes.
    function automatic void pack_field(input logic [IN_CNT_W-1:0] cnt,
                                       input logic [VALUE_W-1:0] val,
                                       input logic fl,
                                       ref packed_byte_t res[$]);
        int unsigned  n;
        int unsigned  have;
        logic [63:0]  acc;
        packed_byte_t r;
        n = (cnt > FIELD_BITS_MAX) ? FIELD_BITS_MAX : int'(cnt);
        acc = {32'd0, val} & ((64'd1 << n) - 64'd1);
        acc = (acc << tail_len) | {57'd0, tail_bits};
        have = tail_len + n;
        stream_bits = stream_bits + TOTAL_W'(n);
        res.delete();
        while (have >= BYTE_W && res.size() < MAX_RESULTS)
        begin
            r = '{1'b1, acc[BYTE_W-1:0], 1'b0, stream_bits};
            res.push_back(r);
            acc = acc >> BYTE_W;
            have -= BYTE_W;
        end
        // flush: tail goes out zero padded
        if (fl && have > 0 && res.size() < MAX_RESULTS)
        begin
            r = '{1'b1, acc[BYTE_W-1:0], 1'b0, stream_bits};
            res.push_back(r);
            acc = '0;
            have = 0;
        end
        tail_bits = acc[PART_W-1:0];
        tail_len = have[PCNT_W-1:0];
        if (res.size() == 0)
        begin
            r = '{1'b0, 8'h00, 1'b0, stream_bits};
            res.push_back(r);
        end
        res[res.size()-1].last = 1'b1;
    endfunction

    // Offer one field and hold it until the transfer happens. push is only
    // lowered during idle cycles so it never toggles within one step.
    task automatic send_field(input field_row_t row);
        packed_byte_t res[$];
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        bit_count   <= row.cnt;
        field_value <= row.val;
        flush       <= row.fl;
        do
            @(posedge clk);
        while (full);
        pack_field(row.cnt, row.val, row.fl, res);
        if (row.typed)
            pending_bytes.push_back('{row.t_valid, row.t_byte, 1'b1, row.t_total});
        else
            foreach (res[i])
                pending_bytes.push_back(res[i]);
    endtask

    function automatic field_row_t random_field();
        field_row_t row;
        int         sel;
        row = '0;
        sel = $urandom_range(99);
        if (sel < 65)
            row.cnt = IN_CNT_W'($urandom_range(32));
        else if (sel < 78)
            row.cnt = ($urandom_range(1) == 1) ? 6'd32 : 6'd0;
        else if (sel < 90)
            row.cnt = IN_CNT_W'($urandom_range(7, 1));
        else
            row.cnt = IN_CNT_W'($urandom_range(63, 33));   // saturating counts
        sel = $urandom_range(99);
        if (sel < 60)
            row.val = $urandom;
        else if (sel < 75)
            row.val = '1;
        else if (sel < 85)
            row.val = '0;
        else
            row.val = VALUE_W'(1) << $urandom_range(31);
        row.fl = ($urandom_range(4) == 0);
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random pop, compare each transfer with the oldest entry
    // ------------------------------------------------------------------
    initial
    begin : result_check
        packed_byte_t exp_r;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("result with nothing pending: byte_out %02h total_bits %0d",
                           byte_out, total_bits);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_bytes.pop_front();
                    if (byte_valid !== exp_r.valid)
                    begin
                        $error("byte_valid: expected %0b, got %0b", exp_r.valid, byte_valid);
                        error_count++;
                    end
                    if (byte_out !== exp_r.value)
                    begin
                        $error("byte_out: expected %02h, got %02h", exp_r.value, byte_out);
                        error_count++;
                    end
                    if (last !== exp_r.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_r.last, last);
                        error_count++;
                    end
                    if (total_bits !== exp_r.total)
                    begin
                        $error("total_bits: expected %0d, got %0d", exp_r.total, total_bits);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Ends the run if neither side moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || stream_done)
                quiet = 0;
            else
                quiet++;
        end
        $display("lsb_first_bit_packer_core test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_field(dir_rows[i]);

        // idle patterns: none, sender idle, receiver stalled, both light
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 86; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 86; end
                default: begin send_idle_pct = 15; pop_stall_pct = 15; end
            endcase
            repeat (RAND_PER_PHASE)
                send_field(random_field());
        end
        push <= 1'b0;

        pop_stall_pct = 0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        stream_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_bytes.size() == 0)
            $display("lsb_first_bit_packer_core test passed");
        else
            $display("lsb_first_bit_packer_core test failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/lbp_pkg.sv
hdl/lbp_front.sv
hdl/lbp_queue.sv
hdl/lbp_back.sv
hdl/lsb_first_bit_packer_core.sv
verif/tb_top.sv
